/* rtl/ray_circle_nearest_hit_defines.svh */
// Assertion macros for the ray/circle nearest hit block.
`ifndef RAY_CIRCLE_NEAREST_HIT_DEFINES_SVH
`define RAY_CIRCLE_NEAREST_HIT_DEFINES_SVH

// Checked at every clock edge once reset is released.
`define RCNH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define RCNH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rcnh_pkg.sv */
// Shared constants for the ray/circle nearest hit block.
`timescale 1ns / 1ps
package rcnh_pkg;

  localparam int COORD_W  = 20;
  localparam int DIR_W    = 16;
  localparam int RAD_W    = 16;
  localparam int LEN_W    = 20;
  localparam int END_W    = 21;
  localparam int CFG_IDX_W = 3;

  localparam int DIR_FRAC_BITS_DEF = 14;

  localparam int LEN_MAX = 1048575;
  localparam int END_MAX = 1048575;
  localparam int END_MIN = -1048576;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 3'd4;

  // reset values
  localparam logic [COORD_W-1:0] ORIGIN_RST     = 20'd0;
  localparam logic [DIR_W-1:0]   DIR_X_RST      = 16'd16384;
  localparam logic [DIR_W-1:0]   DIR_Y_RST      = 16'd0;
  localparam logic [LEN_W-1:0]   MAX_LENGTH_RST = 20'd80000;

endpackage

/* rtl/ray_circle_nearest_hit.sv */
// Ray/circle intersection with nearest-hit tracking, bit-serial datapath.
`timescale 1ns / 1ps
// One circle per input transaction is tested against the configured ray
// (origin, unit direction Qx.F with F = DIR_FRAC_BITS). The block works on one
// circle at a time: a single shift-add multiplier retires one multiplier bit
// per cycle and runs eight products (ex^2, ey^2, ex*dx, ey*dy, a^2, r^2,
// dx*nearest, dy*nearest), each preceded by a load step, and a square-root
// unit retires one result bit (two radicand bits) per cycle. The multiplier
// width is 25 and the root width 26 at F = 14; when r^2 < b2 the root is
// skipped. The finished result sits in an output register, so the next
// circle is taken while it waits; a result still held there when the next
// one is done stalls the block until out_tready frees it. A hit shortens
// the nearest length only when its saturated length is strictly below it;
// in_tuser high restarts the sweep at max_length. Configuration must be
// written only while idle; the block itself does not enforce it. A new
// max_length applies at the next sweep start.
// There is no memory and no clearing pass after reset.
`include "ray_circle_nearest_hit_defines.svh"

module ray_circle_nearest_hit #(
  parameter int DIR_FRAC_BITS = rcnh_pkg::DIR_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [19:0] cfg_wdata,
  // circle in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // center_x[19:0], center_y[39:20], radius[55:40]
  input  logic        in_tuser,   // new_sweep
  // result out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // hit_len[19:0], nearest_len[39:20],
                                  // end_dx[60:40], end_dy[81:61], zero pad
  output logic        out_tuser   // hit
);

  // dot product sum width, projection width, multiplier width
  localparam int S_W    = 38;
  localparam int A_W    = S_W - DIR_FRAC_BITS + 1;
  localparam int MP_W   = (A_W > 21) ? A_W : 21;
  localparam int ACC_W  = 2 * MP_W + 2;
  localparam int RT_W   = ACC_W / 2;
  localparam int REM_W  = RT_W + 2;
  localparam int T_W    = RT_W + 2;
  localparam int CNT_W  = $clog2(RT_W + 1);

  localparam logic signed [ACC_W-1:0] RND_HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (DIR_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] END_HI = ACC_W'(rcnh_pkg::END_MAX);
  localparam logic signed [ACC_W-1:0] END_LO = ACC_W'(rcnh_pkg::END_MIN);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_SQRT, ST_HIT, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_EXX, OP_EYY, OP_EXD, OP_EYD, OP_AA, OP_RR, OP_NDX, OP_NDY
  } op_t;

  state_t state_r;
  op_t    op_r;

  // configuration
  logic signed [19:0] origin_x_r, origin_y_r;
  logic signed [15:0] dir_x_r, dir_y_r;
  logic [19:0]        max_len_r;

  // item and datapath
  logic signed [20:0]      ex_r, ey_r;
  logic [15:0]             rad_r;
  logic [19:0]             nearest_r;
  logic signed [ACC_W-1:0] acc_r, mc_r, e2_r, b2_r, r2_r, sq_v_r;
  logic [MP_W-1:0]         mp_r;
  logic signed [MP_W-1:0]  a_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [REM_W-1:0]        rem_r;
  logic [RT_W-1:0]         root_r;
  logic                    ok_r, hit_r;
  logic [19:0]             hit_len_r;
  logic [20:0]             end_dx_r, end_dy_r;

  // output register
  logic        out_valid_r, out_hit_r;
  logic [19:0] out_hit_len_r, out_near_r;
  logic [20:0] out_dx_r, out_dy_r;

  // combinational datapath
  logic signed [ACC_W-1:0] mc_ld, term, acc_sum, rnd_sum, rnd_val;
  logic [MP_W-1:0]         mp_ld;
  logic                    mul_last, sq_last, op_clear;
  logic [20:0]             end_sat;
  logic [REM_W-1:0]        rem_sh, trial;
  logic signed [T_W-1:0]   t_val;
  logic                    t_neg, hit_c;
  logic [19:0]             hl_c;

  always_comb begin
    mc_ld    = '0;
    mp_ld    = '0;
    op_clear = 1'b1;
    case (op_r)
      OP_EXX: begin mc_ld = ACC_W'(ex_r);    mp_ld = MP_W'(ex_r); end
      OP_EYY: begin
        mc_ld = ACC_W'(ey_r); mp_ld = MP_W'(ey_r); op_clear = 1'b0;
      end
      OP_EXD: begin mc_ld = ACC_W'(ex_r);    mp_ld = MP_W'(dir_x_r); end
      OP_EYD: begin
        mc_ld = ACC_W'(ey_r); mp_ld = MP_W'(dir_y_r); op_clear = 1'b0;
      end
      OP_AA:  begin mc_ld = ACC_W'(a_r);     mp_ld = MP_W'(a_r); end
      OP_RR:  begin mc_ld = ACC_W'(rad_r);   mp_ld = MP_W'(rad_r); end
      OP_NDX: begin mc_ld = ACC_W'(dir_x_r); mp_ld = MP_W'(nearest_r); end
      OP_NDY: begin mc_ld = ACC_W'(dir_y_r); mp_ld = MP_W'(nearest_r); end
      default: begin mc_ld = '0; mp_ld = '0; end
    endcase
  end

  // multiplier MSB carries negative weight
  assign mul_last = (cnt_r == CNT_W'(MP_W - 1));
  assign term     = mp_r[0] ? (mul_last ? -mc_r : mc_r) : '0;
  assign acc_sum  = acc_r + term;
  assign rnd_sum  = acc_sum + RND_HALF;
  assign rnd_val  = rnd_sum >>> DIR_FRAC_BITS;

  always_comb begin
    if (rnd_val > END_HI) begin
      end_sat = 21'h0FFFFF;
    end else if (rnd_val < END_LO) begin
      end_sat = 21'h100000;
    end else begin
      end_sat = rnd_val[20:0];
    end
  end

  // one root bit per cycle
  assign sq_last = (cnt_r == CNT_W'(RT_W - 1));
  assign rem_sh  = {rem_r[REM_W-3:0], sq_v_r[ACC_W-1 -: 2]};
  assign trial   = {root_r, 2'b01};

  // hit length: a + f inside the circle, a - f outside
  always_comb begin
    if (e2_r < r2_r) begin
      t_val = T_W'(a_r) + T_W'(root_r);
    end else begin
      t_val = T_W'(a_r) - T_W'(root_r);
    end
    t_neg = t_val[T_W-1];
    hit_c = ok_r && !t_neg;
    if (!hit_c) begin
      hl_c = '0;
    end else if (t_val[T_W-2:0] > (T_W-1)'(rcnh_pkg::LEN_MAX)) begin
      hl_c = 20'hFFFFF;
    end else begin
      hl_c = t_val[19:0];
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_EXX;
      origin_x_r  <= rcnh_pkg::ORIGIN_RST;
      origin_y_r  <= rcnh_pkg::ORIGIN_RST;
      dir_x_r     <= rcnh_pkg::DIR_X_RST;
      dir_y_r     <= rcnh_pkg::DIR_Y_RST;
      max_len_r   <= rcnh_pkg::MAX_LENGTH_RST;
      nearest_r   <= rcnh_pkg::MAX_LENGTH_RST;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          rcnh_pkg::REG_ORIGIN_X:   origin_x_r <= cfg_wdata;
          rcnh_pkg::REG_ORIGIN_Y:   origin_y_r <= cfg_wdata;
          rcnh_pkg::REG_DIR_X:      dir_x_r    <= cfg_wdata[15:0];
          rcnh_pkg::REG_DIR_Y:      dir_y_r    <= cfg_wdata[15:0];
          rcnh_pkg::REG_MAX_LENGTH: max_len_r  <= cfg_wdata;
          default: ;
        endcase
      end

      // ST_DONE reloads the output register itself
      if (out_valid_r && out_tready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            ex_r  <= 21'($signed(in_tdata[19:0])) - 21'(origin_x_r);
            ey_r  <= 21'($signed(in_tdata[39:20])) - 21'(origin_y_r);
            rad_r <= in_tdata[55:40];
            if (in_tuser) begin
              nearest_r <= max_len_r;
            end
            op_r    <= OP_EXX;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          mc_r    <= mc_ld;
          mp_r    <= mp_ld;
          cnt_r   <= '0;
          if (op_clear) begin
            acc_r <= '0;
          end
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          acc_r <= acc_sum;
          mc_r  <= mc_r <<< 1;
          mp_r  <= mp_r >> 1;
          cnt_r <= mul_last ? '0 : cnt_r + 1'b1;
          if (mul_last) begin
            unique case (op_r)
              OP_EXX: begin op_r <= OP_EYY; state_r <= ST_LOAD; end
              OP_EYY: begin e2_r <= acc_sum; op_r <= OP_EXD; state_r <= ST_LOAD; end
              OP_EXD: begin op_r <= OP_EYD; state_r <= ST_LOAD; end
              OP_EYD: begin
                a_r     <= rnd_val[MP_W-1:0];
                op_r    <= OP_AA;
                state_r <= ST_LOAD;
              end
              OP_AA: begin
                b2_r    <= e2_r - acc_sum;
                op_r    <= OP_RR;
                state_r <= ST_LOAD;
              end
              OP_RR: begin
                r2_r   <= acc_sum;
                sq_v_r <= acc_sum - b2_r;
                rem_r  <= '0;
                root_r <= '0;
                if (acc_sum >= b2_r) begin
                  ok_r    <= 1'b1;
                  state_r <= ST_SQRT;
                end else begin
                  ok_r    <= 1'b0;
                  state_r <= ST_HIT;
                end
              end
              OP_NDX: begin end_dx_r <= end_sat; op_r <= OP_NDY; state_r <= ST_LOAD; end
              OP_NDY: begin
                end_dy_r <= end_sat;
                state_r  <= ST_DONE;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_SQRT: begin
          sq_v_r <= sq_v_r <<< 2;
          cnt_r  <= cnt_r + 1'b1;
          if (rem_sh >= trial) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[RT_W-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[RT_W-2:0], 1'b0};
          end
          if (sq_last) begin
            state_r <= ST_HIT;
          end
        end
        ST_HIT: begin
          hit_r     <= hit_c;
          hit_len_r <= hl_c;
          if (hit_c && (hl_c < nearest_r)) begin
            nearest_r <= hl_c;
          end
          op_r    <= OP_NDX;
          state_r <= ST_LOAD;
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r   <= 1'b1;
            out_hit_r     <= hit_r;
            out_hit_len_r <= hit_len_r;
            out_near_r    <= nearest_r;
            out_dx_r      <= end_dx_r;
            out_dy_r      <= end_dy_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {6'd0, out_dy_r, out_dx_r, out_near_r, out_hit_len_r};

  // a missed circle reports zero length
  `RCNH_ASSERT(a_miss_len_zero, out_tvalid && !out_tuser |-> out_tdata[19:0] == 20'd0, "miss with nonzero length")
  // after a hit the nearest length never exceeds that hit
  `RCNH_ASSERT(a_hit_bounds_nearest, out_tvalid && out_tuser |-> out_tdata[39:20] <= out_tdata[19:0], "nearest above hit length")
  // one circle at a time: taking an item closes the input
  `RCNH_ASSERT(a_one_in_flight, in_tvalid && in_tready |=> !in_tready, "input reopened at once")
  // out of reset nothing is pending
  `RCNH_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid && in_tready, "not idle after reset")

endmodule
